// File: design/cau_pkg.sv
// Shared types, constants and saturation helper for the complex arithmetic unit.
// No dependencies; every other design file imports this package.
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS_DEFAULT = 24;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic [PROD_WIDTH-1:0] mag_t;
    typedef logic [2:0] mode_t;

    localparam mode_t MODE_ADD  = 3'd0;
    localparam mode_t MODE_SUB  = 3'd1;
    localparam mode_t MODE_MUL  = 3'd2;
    localparam mode_t MODE_DIV  = 3'd3;
    localparam mode_t MODE_CONJ = 3'd4;
    localparam mode_t MODE_MOD  = 3'd5;

    localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam mag_t MAG_TOP = mag_t'(1) << (DATA_WIDTH - 1);
    localparam mag_t MAG_MAXPOS = MAG_TOP - 1'b1;

    typedef struct packed {
        mode_t mode;
        word_t a_re;
        word_t a_im;
        word_t b_re;
        word_t b_im;
    } cau_in_t;

    typedef struct packed {
        word_t res_re;
        word_t res_im;
        logic  div_zero;
    } cau_out_t;

    typedef struct packed {
        mode_t mode;
        word_t simple_re;
        word_t simple_im;
        logic  dz;
        logic  neg_re;
        logic  neg_im;
    } side_t;

    typedef struct packed {
        side_t side;
        mag_t  num_re;
        mag_t  num_im;
        mag_t  sq_sum;
    } prod_t;

    function automatic word_t sat_mag(input logic neg, input mag_t mag);
        word_t res;
        if (!neg)
        begin
            res = (mag > MAG_MAXPOS) ? WORD_MAX : word_t'(mag[DATA_WIDTH-1:0]);
        end
        else
        begin
            res = (mag >= MAG_TOP) ? WORD_MIN : word_t'(~mag[DATA_WIDTH-1:0] + 1'b1);
        end
        return res;
    endfunction

endpackage

// File: design/cau_prod.sv
// Front two pipeline stages: products and simple results, then sums and magnitudes.
// Depends on cau_pkg.
module cau_prod #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              en,
    input  cau_pkg::cau_in_t  op,
    output cau_pkg::prod_t    prod
);
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int PW = PROD_WIDTH;

    mode_t                mode_reg;
    word_t                sre_reg, sim_reg, sre_next, sim_next;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, q1_reg, q2_reg;
    logic signed [DW-1:0] x1, x2;
    logic signed [DW:0]   s_re, s_im;
    logic signed [PW:0]   sum_re, sum_im, abs_re, abs_im;
    prod_t                prod_reg, prod_next;

    function automatic word_t sat_ext(input logic signed [DW:0] s);
        word_t res;
        if (s[DW] != s[DW-1])
        begin
            res = s[DW] ? WORD_MIN : WORD_MAX;
        end
        else
        begin
            res = word_t'(s[DW-1:0]);
        end
        return res;
    endfunction

    always_comb
    begin
        s_re = (op.mode == MODE_SUB) ? ($signed(op.a_re) - $signed(op.b_re))
                                     : ($signed(op.a_re) + $signed(op.b_re));
        s_im = (op.mode == MODE_SUB) ? ($signed(op.a_im) - $signed(op.b_im))
                                     : ($signed(op.a_im) + $signed(op.b_im));
        sre_next = '0;
        sim_next = '0;
        case (op.mode)
            MODE_ADD, MODE_SUB:
            begin
                sre_next = sat_ext(s_re);
                sim_next = sat_ext(s_im);
            end
            MODE_CONJ:
            begin
                sre_next = op.a_re;
                sim_next = sat_ext(-$signed({op.a_im[DW-1], op.a_im}));
            end
            default:
            begin
                sre_next = '0;
                sim_next = '0;
            end
        endcase
        x1 = (op.mode == MODE_MOD) ? op.a_re : op.b_re;
        x2 = (op.mode == MODE_MOD) ? op.a_im : op.b_im;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg <= op.mode;
            sre_reg  <= sre_next;
            sim_reg  <= sim_next;
            p_rr_reg <= $signed(op.a_re) * $signed(op.b_re);
            p_ii_reg <= $signed(op.a_im) * $signed(op.b_im);
            p_ri_reg <= $signed(op.a_re) * $signed(op.b_im);
            p_ir_reg <= $signed(op.a_im) * $signed(op.b_re);
            q1_reg   <= x1 * x1;
            q2_reg   <= x2 * x2;
        end
    end

    always_comb
    begin
        sum_re = (mode_reg == MODE_MUL) ? (p_rr_reg - p_ii_reg) : (p_rr_reg + p_ii_reg);
        sum_im = (mode_reg == MODE_MUL) ? (p_ri_reg + p_ir_reg) : (p_ir_reg - p_ri_reg);
        abs_re = sum_re[PW] ? -sum_re : sum_re;
        abs_im = sum_im[PW] ? -sum_im : sum_im;
        prod_next.num_re = abs_re[PW-1:0];
        prod_next.num_im = abs_im[PW-1:0];
        prod_next.sq_sum = mag_t'(q1_reg) + mag_t'(q2_reg);
        prod_next.side.mode = mode_reg;
        prod_next.side.neg_re = sum_re[PW];
        prod_next.side.neg_im = sum_im[PW];
        prod_next.side.dz = (mode_reg == MODE_DIV) && (prod_next.sq_sum == '0);
        if (mode_reg == MODE_MUL)
        begin
            prod_next.side.simple_re = sat_mag(sum_re[PW], abs_re[PW-1:0] >> FRAC_BITS);
            prod_next.side.simple_im = sat_mag(sum_im[PW], abs_im[PW-1:0] >> FRAC_BITS);
        end
        else
        begin
            prod_next.side.simple_re = sre_reg;
            prod_next.side.simple_im = sim_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: design/cau_div_lane.sv
// Pipelined restoring divider: an overflow check, then one quotient bit per stage; DATA_WIDTH stages.
// Depends on cau_pkg.
module cau_div_lane #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              en,
    input  cau_pkg::mag_t                     num,
    input  cau_pkg::mag_t                     den,
    output logic [cau_pkg::DATA_WIDTH-2:0]    quo,
    output logic                              ovf
);
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int PW = PROD_WIDTH;
    localparam int NW = PW + FRAC_BITS;

    logic [NW-1:0] n_full, r0_full;
    mag_t          rem_reg [DW];
    mag_t          rem_next [DW];
    mag_t          den_reg [DW];
    logic [DW-2:0] q_reg [DW];
    logic [DW-2:0] q_next [DW];
    logic [DW-2:0] nlow_reg [DW];
    logic [DW-2:0] nlow_next [DW];
    logic          ovf_reg [DW];
    logic          ovf0;
    logic [PW:0]   trial [1:DW-1];
    logic [PW:0]   diff [1:DW-1];
    logic          take [1:DW-1];

    always_comb
    begin
        n_full = {num, {FRAC_BITS{1'b0}}};
        r0_full = n_full >> (DW - 1);
        ovf0 = r0_full >= {{FRAC_BITS{1'b0}}, den};
        rem_next[0] = r0_full[PW-1:0];
        q_next[0] = '0;
        nlow_next[0] = n_full[DW-2:0];
        for (int k = 1; k < DW; k++)
        begin
            trial[k] = {rem_reg[k-1], nlow_reg[k-1][DW-2]};
            take[k] = trial[k] >= {1'b0, den_reg[k-1]};
            diff[k] = trial[k] - {1'b0, den_reg[k-1]};
            rem_next[k] = take[k] ? diff[k][PW-1:0] : trial[k][PW-1:0];
            q_next[k] = {q_reg[k-1][DW-3:0], take[k]};
            nlow_next[k] = {nlow_reg[k-1][DW-3:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            q_reg[0]    <= q_next[0];
            nlow_reg[0] <= nlow_next[0];
            den_reg[0]  <= den;
            ovf_reg[0]  <= ovf0;
            for (int k = 1; k < DW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
                nlow_reg[k] <= nlow_next[k];
                den_reg[k]  <= den_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
            end
        end
    end

    assign quo = q_reg[DW-1];
    assign ovf = ovf_reg[DW-1];

endmodule

// File: design/cau_sqrt_lane.sv
// Pipelined integer square root: one result bit per stage, DATA_WIDTH stages.
// Depends on cau_pkg.
module cau_sqrt_lane (
    input  logic          clk,
    input  logic          en,
    input  cau_pkg::mag_t rad,
    output cau_pkg::mag_t root
);
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int PW = PROD_WIDTH;

    typedef struct packed {
        mag_t s;
        mag_t r;
    } sq_t;

    sq_t sq_reg [DW];
    sq_t sq_next [DW];

    function automatic sq_t sq_step(input mag_t s, input mag_t r, input mag_t b);
        sq_t  o;
        mag_t cand;
        cand = r + b;
        if (s >= cand)
        begin
            o.s = s - cand;
            o.r = (r >> 1) + b;
        end
        else
        begin
            o.s = s;
            o.r = r >> 1;
        end
        return o;
    endfunction

    always_comb
    begin
        sq_next[0] = sq_step(rad, '0, mag_t'(1) << (PW - 2));
        for (int k = 1; k < DW; k++)
        begin
            sq_next[k] = sq_step(sq_reg[k-1].s, sq_reg[k-1].r, mag_t'(1) << (PW - 2 - 2 * k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DW; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
        end
    end

    assign root = sq_reg[DW-1].r;

endmodule

// File: design/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: front stages, divider and root lanes, output skid.
// Depends on cau_pkg, cau_prod, cau_div_lane and cau_sqrt_lane.
//
// Usage: an operation transfer on op (op_valid high, op_stall low) carries a mode and two
// complex operands in signed fixed point. Each operation yields exactly one result transfer
// on res (res_valid high, res_stall low), in the order the operations arrived.
// The divider and square root lanes resolve their results one bit per pipeline stage.
// One operation is accepted every cycle while op_stall is low.
// Division by zero returns zero with div_zero set; all results saturate.
// Reset clears every valid bit in the pipeline and the output stage.
// When the receiver stalls, the held result stays on res and the next finished result
// moves into a one-entry skid buffer; only once that buffer is full does op_stall rise
// and the whole pipeline hold. The block stays free of any clearing pass after reset.
module complex_arithmetic_unit_core #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_stall,
    input  cau_pkg::cau_in_t  op,
    output logic              res_valid,
    input  logic              res_stall,
    output cau_pkg::cau_out_t res
);
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int NSTG = DW + 2;

    logic              pipe_en;
    logic [NSTG-1:0]   stage_valid_reg;
    prod_t             prod;
    side_t             side_reg [DW];
    side_t             tail_side;
    logic [DW-2:0]     quo_re, quo_im;
    logic              ovf_re, ovf_im;
    mag_t              root;
    cau_out_t          tail_next;
    logic              tail_valid;
    logic              out_valid_reg, skid_valid_reg, out_take;
    cau_out_t          out_reg, skid_reg;

    assign pipe_en = !skid_valid_reg;
    assign op_stall = skid_valid_reg;

    cau_prod #(.FRAC_BITS(FRAC_BITS)) u_prod (
        .clk  (clk),
        .en   (pipe_en),
        .op   (op),
        .prod (prod)
    );

    cau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .clk (clk),
        .en  (pipe_en),
        .num (prod.num_re),
        .den (prod.sq_sum),
        .quo (quo_re),
        .ovf (ovf_re)
    );

    cau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .clk (clk),
        .en  (pipe_en),
        .num (prod.num_im),
        .den (prod.sq_sum),
        .quo (quo_im),
        .ovf (ovf_im)
    );

    cau_sqrt_lane u_sqrt (
        .clk  (clk),
        .en   (pipe_en),
        .rad  (prod.sq_sum),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            side_reg[0] <= prod.side;
            for (int k = 1; k < DW; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else if (pipe_en)
        begin
            stage_valid_reg <= {stage_valid_reg[NSTG-2:0], op_valid};
        end
    end

    assign tail_valid = stage_valid_reg[NSTG-1];
    assign tail_side = side_reg[DW-1];

    always_comb
    begin
        tail_next.res_re = tail_side.simple_re;
        tail_next.res_im = tail_side.simple_im;
        tail_next.div_zero = 1'b0;
        case (tail_side.mode)
            MODE_DIV:
            begin
                if (tail_side.dz)
                begin
                    tail_next.res_re = '0;
                    tail_next.res_im = '0;
                    tail_next.div_zero = 1'b1;
                end
                else
                begin
                    tail_next.res_re = sat_mag(tail_side.neg_re,
                                               ovf_re ? MAG_TOP : mag_t'(quo_re));
                    tail_next.res_im = sat_mag(tail_side.neg_im,
                                               ovf_im ? MAG_TOP : mag_t'(quo_im));
                end
            end
            MODE_MOD:
            begin
                tail_next.res_re = sat_mag(1'b0, root);
                tail_next.res_im = '0;
            end
            default:
            begin
                tail_next.div_zero = 1'b0;
            end
        endcase
    end

    assign out_take = out_valid_reg && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (tail_valid)
        begin
            if (out_valid_reg && res_stall)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (tail_valid)
        begin
            if (out_valid_reg && res_stall)
            begin
                skid_reg <= tail_next;
            end
            else
            begin
                out_reg <= tail_next;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res = out_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer holds a result while the output stage is empty");

    a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(stage_valid_reg))
        else $error("pipeline advanced while the skid buffer was full");

    a_div_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.div_zero |-> (res.res_re == '0) && (res.res_im == '0))
        else $error("division by zero returned a nonzero result");
`endif

endmodule
